@@ rtl/sdf_pkg.sv @@
// Package for the signed decimal formatter: field widths, character codes,
// the sequencer's step, operation and condition codes, and its control store.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

	localparam int VALUE_W    = 64;
	localparam int PREC_W     = 7;
	localparam int CHAR_W     = 8;
	localparam int MAX_DIGITS = 20;
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int PAD_W      = PREC_W - 1;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	// Steps of the microprogram.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_SCAN,
		ST_PADS,
		ST_SIGN,
		ST_PAD,
		ST_DIGIT
	} step_t;

	// Datapath operations selected by a control word.
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_SHIFT,
		OP_SCAN,
		OP_PADS,
		OP_SIGN,
		OP_PAD,
		OP_DIGIT
	} op_t;

	// Branch conditions tested by a control word.
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_BIT_DONE,
		C_TOP_FOUND,
		C_PAD_DONE,
		C_DIGIT_END
	} cond_t;

	// One control word: the operation, the branch test, the target taken when
	// the test holds and the step that follows otherwise.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} ctrl_t;

	// Control store of the sequencer.
	function automatic ctrl_t rom_word(step_t s);
		ctrl_t w;
		case (s)
			ST_IDLE:   w = '{op: OP_LOAD,  cond: C_ALWAYS,    jmp: ST_DABBLE, nxt: ST_DABBLE};
			ST_DABBLE: w = '{op: OP_SHIFT, cond: C_BIT_DONE,  jmp: ST_SCAN,   nxt: ST_DABBLE};
			ST_SCAN:   w = '{op: OP_SCAN,  cond: C_TOP_FOUND, jmp: ST_PADS,   nxt: ST_SCAN};
			ST_PADS:   w = '{op: OP_PADS,  cond: C_ALWAYS,    jmp: ST_SIGN,   nxt: ST_SIGN};
			ST_SIGN:   w = '{op: OP_SIGN,  cond: C_ALWAYS,    jmp: ST_PAD,    nxt: ST_PAD};
			ST_PAD:    w = '{op: OP_PAD,   cond: C_PAD_DONE,  jmp: ST_DIGIT,  nxt: ST_PAD};
			ST_DIGIT:  w = '{op: OP_DIGIT, cond: C_DIGIT_END, jmp: ST_IDLE,   nxt: ST_DIGIT};
			default:   w = '{op: OP_LOAD,  cond: C_ALWAYS,    jmp: ST_IDLE,   nxt: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/sdf_if.sv @@
// Channel interfaces of the signed decimal formatter: the number input and
// the character output, each with valid, ready and payload. Depends on sdf_pkg.
`timescale 1ns / 1ps

interface sdf_in_if;
	import sdf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sdf_out_if;
	import sdf_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              last_char;

	modport source (output valid, output char_out, output last_char, input ready);
	modport sink (input valid, input char_out, input last_char, output ready);
endinterface

@@ rtl/signed_decimal_formatter.sv @@
// Top level of the signed decimal formatter: a microcoded sequencer that turns
// a signed 64-bit number into printf-style decimal ASCII characters.
// Depends on sdf_pkg and the channel interfaces in sdf_if.
//
// One number is taken at a time; number.ready is high only while the block
// waits for the next one. Each number goes through a load step, shift-and-add-3
// binary to decimal conversion of all 64 magnitude bits (one magnitude bit a
// cycle), a scan over up to 20 digit positions for the leading digit, a step
// that works out the padding, a sign step whether or not a '-' is sent, a
// padding step for each '0' plus one to leave the padding step, and a digit
// step for each digit (a single step when a zero gives no text). Results leave
// through a one-entry output register, so the block keeps working while a
// character waits to be taken. The precision register is to be written with
// cfg_we and cfg_wdata only while the block is idle; the user is bound to this
// and the block itself does not enforce it. Any negative precision means that
// none is given.
`timescale 1ns / 1ps

module signed_decimal_formatter (
	input  logic                             clk,
	input  logic                             arst_n,
	sdf_in_if.sink                           number,
	sdf_out_if.source                        text,
	input  logic                             cfg_we,
	input  logic signed [sdf_pkg::PREC_W-1:0] cfg_wdata
);
	import sdf_pkg::*;

	// Control state.
	step_t                     pc_q;
	logic                      out_v_q;
	logic signed [PREC_W-1:0]  prec_q;

	// Datapath registers.
	logic [VALUE_W-1:0]        mag_q;
	logic [BIT_CNT_W-1:0]      cnt_q;
	logic [3:0]                digit_q [MAX_DIGITS];
	logic [IDX_W-1:0]          idx_q;
	logic [PAD_W-1:0]          pad_q;
	logic                      neg_q;
	logic                      zero_q;
	logic [CHAR_W-1:0]         char_q;
	logic                      last_q;

	ctrl_t                     cw;
	logic                      slot_ok;
	logic                      emit;
	logic                      stall;
	logic                      cond_ok;
	logic                      skip;
	logic                      top_found;
	logic [3:0]                cur_digit;
	logic [3:0]                adj [MAX_DIGITS];
	logic [PAD_W-1:0]          sig_len;
	logic [PAD_W-1:0]          pad_calc;
	logic [CHAR_W-1:0]         emit_char;

	// Current control word.
	assign cw = rom_word(pc_q);

	// Add-3 correction on every decimal lane before the next shift.
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[i] = (digit_q[i] >= 4'd5) ? digit_q[i] + 4'd3 : digit_q[i];
		end
	end

	// Digit read, leading digit test and padding arithmetic.
	assign cur_digit = digit_q[idx_q];
	assign top_found = (cur_digit != 4'd0) || (idx_q == '0);
	assign skip      = zero_q && (prec_q == '0);
	assign sig_len   = PAD_W'({1'b0, idx_q}) + PAD_W'(1);
	assign pad_calc  = (!prec_q[PREC_W-1] && (prec_q[PAD_W-1:0] > sig_len))
		? prec_q[PAD_W-1:0] - sig_len : '0;

	// Branch condition of the current step.
	always_comb begin
		case (cw.cond)
			C_ALWAYS:    cond_ok = 1'b1;
			C_BIT_DONE:  cond_ok = (cnt_q == '0);
			C_TOP_FOUND: cond_ok = top_found;
			C_PAD_DONE:  cond_ok = (pad_q == '0);
			C_DIGIT_END: cond_ok = (idx_q == '0) || skip;
			default:     cond_ok = 1'b1;
		endcase
	end

	// Character requested by the current step.
	always_comb begin
		case (cw.op)
			OP_SIGN:  begin
				emit      = neg_q;
				emit_char = CHAR_MINUS;
			end
			OP_PAD:   begin
				emit      = (pad_q != '0);
				emit_char = CHAR_ZERO;
			end
			OP_DIGIT: begin
				emit      = !skip;
				emit_char = CHAR_ZERO + CHAR_W'(cur_digit);
			end
			default:  begin
				emit      = 1'b0;
				emit_char = CHAR_ZERO;
			end
		endcase
	end

	// A step holds while it waits for a number or for room in the output register.
	assign slot_ok = !out_v_q || text.ready;
	assign stall   = ((cw.op == OP_LOAD) && !number.valid) || (emit && !slot_ok);

	assign number.ready   = (pc_q == ST_IDLE);
	assign text.valid     = out_v_q;
	assign text.char_out  = char_q;
	assign text.last_char = last_q;

	// Sequencer, output valid and precision register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= ST_IDLE;
			out_v_q <= 1'b0;
			prec_q  <= '1;
		end else begin
			if (cfg_we) begin
				prec_q <= cfg_wdata;
			end
			if (!stall) begin
				pc_q <= cond_ok ? cw.jmp : cw.nxt;
			end
			if (emit && !stall) begin
				out_v_q <= 1'b1;
			end else if (text.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Datapath, driven by the operation of the current control word.
	always_ff @(posedge clk) begin
		if (!stall) begin
			case (cw.op)
				OP_LOAD:  begin
					neg_q  <= number.value[VALUE_W-1];
					mag_q  <= number.value[VALUE_W-1]
						? VALUE_W'(0) - VALUE_W'(number.value) : VALUE_W'(number.value);
					zero_q <= (number.value == '0);
					cnt_q  <= BIT_CNT_W'(VALUE_W - 1);
					idx_q  <= IDX_W'(MAX_DIGITS - 1);
					for (int i = 0; i < MAX_DIGITS; i++) begin
						digit_q[i] <= 4'd0;
					end
				end
				OP_SHIFT: begin
					digit_q[0] <= {adj[0][2:0], mag_q[VALUE_W-1]};
					for (int i = 1; i < MAX_DIGITS; i++) begin
						digit_q[i] <= {adj[i][2:0], adj[i-1][3]};
					end
					mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
					cnt_q <= cnt_q - BIT_CNT_W'(1);
				end
				OP_SCAN:  begin
					if (!top_found) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				OP_PADS:  begin
					pad_q <= pad_calc;
				end
				OP_PAD:   begin
					if (pad_q != '0) begin
						pad_q <= pad_q - PAD_W'(1);
					end
				end
				OP_DIGIT: begin
					if (!skip && (idx_q != '0)) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				default:  begin
				end
			endcase
			if (emit) begin
				char_q <= emit_char;
				last_q <= (cw.op == OP_DIGIT) && (idx_q == '0);
			end
		end
	end

	// Every character shown is a minus sign or a decimal digit.
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.char_out == CHAR_MINUS)
			|| ((text.char_out >= CHAR_ZERO) && (text.char_out <= CHAR_NINE)))
		else $error("character out of range");

	// The minus sign is never the final character.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.last_char) |-> (text.char_out != CHAR_MINUS))
		else $error("minus sign marked as last");

	// A number is only taken once the previous text has been fully handed over
	// or sits in the output register as its final character.
	a_load_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(number.valid && number.ready && text.valid) |-> text.last_char)
		else $error("number taken while its predecessor is unfinished");

	// The padding never exceeds what the precision allows.
	a_pad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((pc_q == ST_PAD) && (pad_q != '0))
			|-> (!prec_q[PREC_W-1] && (pad_q < prec_q[PAD_W-1:0])))
		else $error("padding count out of range");

endmodule

@@ sim/signed_decimal_formatter_test.sv @@
// Self-checking testbench for signed_decimal_formatter: drives signed numbers
// under several precision settings and checks every character transfer.
// Depends on sdf_pkg, the channel interfaces in sdf_if and the top level RTL.
`timescale 1ns / 1ps

module signed_decimal_formatter_test;
	import sdf_pkg::*;

	localparam int HALF_PERIOD    = 6;
	// A number that yields no text still occupies the block after it is taken.
	localparam int SETTLE_CYCLES  = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASE_ITEMS    = 18;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last_flag;
	} text_char_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic signed [PREC_W-1:0] cfg_wdata;

	sdf_in_if  number_if ();
	sdf_out_if text_if ();

	signed_decimal_formatter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.number    (number_if),
		.text      (text_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [VALUE_W-1:0]       pending_numbers [$];
	text_char_t               expected_chars [$];
	logic signed [PREC_W-1:0] precision_model;
	text_char_t               wanted_char;
	int                       mismatches;
	int                       idle_cycles;
	int unsigned              send_gap;
	int unsigned              recv_stall;
	int unsigned              next_stall;
	bit                       calm;
	int                       precision_plan [8] = '{0, 63, -64, -1, 1, 19, 20, 2};

	// Clock generation.
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Gap length between transfers: mostly short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Works out the text of one number under the current precision and queues
	// its characters, the final one flagged.
	function automatic void format_number(logic [VALUE_W-1:0] raw);
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digits [MAX_DIGITS];
		int                 ndig;
		int                 sig_len;
		int                 pads;
		text_char_t         line [$];
		mag  = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
		ndig = 0;
		pads = 0;
		while (mag != 0) begin
			digits[ndig] = 4'(mag % 10);
			mag = mag / 10;
			ndig++;
		end
		// Zero still counts as one digit when the padding is worked out.
		sig_len = (ndig == 0) ? 1 : ndig;
		if (precision_model >= 0 && int'(precision_model) > sig_len)
			pads = int'(precision_model) - sig_len;
		if (raw[VALUE_W-1])
			line.push_back('{ch: CHAR_MINUS, last_flag: 1'b0});
		repeat (pads) line.push_back('{ch: CHAR_ZERO, last_flag: 1'b0});
		if (ndig == 0) begin
			// Zero with precision 0 has no text at all.
			if (precision_model != 0)
				line.push_back('{ch: CHAR_ZERO, last_flag: 1'b0});
		end else begin
			for (int i = ndig - 1; i >= 0; i--)
				line.push_back('{ch: CHAR_ZERO + CHAR_W'(digits[i]), last_flag: 1'b0});
		end
		if (line.size() != 0)
			line[line.size() - 1].last_flag = 1'b1;
		foreach (line[i]) expected_chars.push_back(line[i]);
	endfunction

	// Random number: zeros, small values, values around powers of ten and values of every length.
	function automatic logic [VALUE_W-1:0] random_number();
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] ten_pow;
		int                 small_v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: begin
				v = '0;
			end
			1: begin
				small_v = int'($urandom_range(0, 40)) - 20;
				v = {{32{small_v[31]}}, small_v};
			end
			2: begin
				ten_pow = 1;
				repeat ($urandom_range(0, 18)) ten_pow = ten_pow * 10;
				v = ten_pow - 1 + $urandom_range(0, 2);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
			3, 4: begin
				v = v;
			end
			default: begin
				v = v >> $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					v = ~v + 1'b1;
			end
		endcase
		return v;
	endfunction

	// Waits until every number has been taken and every character has arrived,
	// then lets the block finish any number that produces no text.
	task automatic drain_and_settle();
		while (pending_numbers.size() != 0 || number_if.valid || expected_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Precision register write; only issued while the block is idle.
	task automatic write_precision(logic signed [PREC_W-1:0] p);
		@(posedge clk);
		cfg_we          <= 1'b1;
		cfg_wdata       <= p;
		precision_model = p;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Number driver: predicts the text of each transfer and presents the next
	// queued number after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_if.valid <= 1'b0;
			number_if.value <= '0;
			send_gap        <= 0;
		end else begin
			if (number_if.valid && number_if.ready)
				format_number(number_if.value);
			if (!number_if.valid || number_if.ready) begin
				if (send_gap != 0) begin
					number_if.valid <= 1'b0;
					send_gap        <= send_gap - 1;
				end else if (pending_numbers.size() != 0) begin
					number_if.valid <= 1'b1;
					number_if.value <= pending_numbers.pop_front();
					send_gap        <= pick_gap();
				end else begin
					number_if.valid <= 1'b0;
				end
			end
		end
	end

	// Character monitor: compares each transfer with the oldest expected
	// character and stalls the output side at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_if.ready <= 1'b0;
			recv_stall    <= 0;
		end else begin
			if (text_if.valid && text_if.ready) begin
				if (expected_chars.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected character %h (last %b) with nothing expected",
							text_if.char_out, text_if.last_char);
					mismatches++;
				end else begin
					wanted_char = expected_chars.pop_front();
					if (text_if.char_out !== wanted_char.ch ||
							text_if.last_char !== wanted_char.last_flag) begin
						if (mismatches < REPORT_LIMIT)
							$display("character mismatch: expected %h last %b, got %h last %b",
								wanted_char.ch, wanted_char.last_flag,
								text_if.char_out, text_if.last_char);
						mismatches++;
					end
				end
			end
			if (recv_stall != 0) begin
				text_if.ready <= 1'b0;
				recv_stall    <= recv_stall - 1;
			end else if (text_if.valid && text_if.ready) begin
				next_stall = pick_gap();
				text_if.ready <= (next_stall == 0);
				recv_stall    <= (next_stall == 0) ? 0 : next_stall - 1;
			end else begin
				text_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((number_if.valid && number_if.ready) || (text_if.valid && text_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("signed_decimal_formatter verification failed");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		int ph;
		mismatches      = 0;
		idle_cycles     = 0;
		calm            = 1'b0;
		precision_model = -1;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed numbers with no precision given.
		pending_numbers.push_back(64'd0);
		pending_numbers.push_back(64'd1);
		pending_numbers.push_back(-64'sd1);
		pending_numbers.push_back(64'd9);
		pending_numbers.push_back(-64'sd10);
		pending_numbers.push_back(64'd1000000000000000000);
		pending_numbers.push_back(64'h7FFF_FFFF_FFFF_FFFF);
		pending_numbers.push_back(64'h8000_0000_0000_0000);
		pending_numbers.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		pending_numbers.push_back(64'h5555_5555_5555_5555);
		drain_and_settle();

		// Precision 0: zero gives no text.
		write_precision(PREC_W'(0));
		pending_numbers.push_back(64'd0);
		pending_numbers.push_back(64'd5);
		pending_numbers.push_back(-64'sd5);
		drain_and_settle();

		// Precision 1: zero gives a single digit.
		write_precision(PREC_W'(1));
		pending_numbers.push_back(64'd0);
		pending_numbers.push_back(64'd7);
		drain_and_settle();

		// Largest precision: the longest text comes from a negative number.
		write_precision(PREC_W'(63));
		pending_numbers.push_back(64'h8000_0000_0000_0000);
		pending_numbers.push_back(64'd0);
		pending_numbers.push_back(64'h7FFF_FFFF_FFFF_FFFF);
		drain_and_settle();

		// Precision below -1 means no precision at all.
		write_precision(PREC_W'(-64));
		pending_numbers.push_back(64'd0);
		pending_numbers.push_back(-64'sd123);
		drain_and_settle();

		// Random phases, the first eight with precisions from a fixed plan that includes the extremes of the register.
		for (ph = 0; ph < 11; ph++) begin
			if (ph < 8)
				write_precision(PREC_W'(precision_plan[ph]));
			else
				write_precision(PREC_W'($urandom_range(0, 127)));
			calm = (ph % 3 == 2);
			repeat (PHASE_ITEMS) pending_numbers.push_back(random_number());
			drain_and_settle();
		end

		if (mismatches == 0 && expected_chars.size() == 0)
			$display("signed_decimal_formatter verification clean");
		else
			$display("signed_decimal_formatter verification failed");
		$finish;
	end

endmodule
